/* rtl/assert_macros.svh */
// Assertion helper macros used by the RTL back end (wnws_back).
// Expects clk and arst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

/* rtl/wnws_pkg.sv */
// Shared types and constants for the windowed nearest waypoint search core.
// No dependencies.
`timescale 1ns / 1ps

package wnws_pkg;

	localparam int unsigned MAX_WAYPOINTS_DEF = 256;

	localparam int unsigned COORD_W = 24;
	localparam int unsigned SLOT_W  = 8;
	localparam int unsigned LEN_W   = 9;
	localparam int unsigned SPAN_W  = LEN_W;
	localparam int unsigned WIN_W   = 8;

	localparam int unsigned DEFAULT_WINDOW = 24;
	localparam int unsigned BACK_LIMIT     = 3;

	localparam int unsigned SQ_W   = 2 * COORD_W;
	localparam int unsigned DIST_W = SQ_W + 2;

	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = LEN_W;
	localparam logic [CFG_IDX_W-1:0] CFG_ROUTE_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROUTE_VALID  = 1'd1;

	localparam int unsigned CMD_Q_DEPTH = 2;
	localparam int unsigned RES_Q_DEPTH = 2;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	// One classified command as queued between front and back.
	typedef struct packed {
		cmd_t              op;
		logic              miss;
		logic [SLOT_W-1:0] slot;
		point_t            pos;
		logic [SPAN_W-1:0] lo;
		logic [SPAN_W-1:0] hi;
		logic              clamp_en;
		logic [SLOT_W-1:0] floor_idx;
	} job_t;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] best_index;
	} result_t;

	// Queue status seen by the back end.
	typedef struct packed {
		logic avail;
		logic room;
	} back_ctl_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_WAIT,
		BK_DONE
	} back_state_t;

endpackage

/* rtl/wnws_fifo.sv */
// Small synchronous queue used for commands and results.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module wnws_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = store_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

/* rtl/wnws_front.sv */
// Front end: configuration registers and command classification.
// Depends on wnws_pkg.
`timescale 1ns / 1ps

module wnws_front #(
	parameter int unsigned MAX_WAYPOINTS = wnws_pkg::MAX_WAYPOINTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [wnws_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [wnws_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic                                 command,
	input  logic [wnws_pkg::SLOT_W-1:0]          entry_index,
	input  wnws_pkg::coord_t                     pos_x,
	input  wnws_pkg::coord_t                     pos_y,
	input  wnws_pkg::coord_t                     pos_z,
	input  logic                                 hint_valid,
	input  logic [wnws_pkg::SLOT_W-1:0]          hint_index,
	input  logic [wnws_pkg::WIN_W-1:0]           hint_window,
	output wnws_pkg::job_t                       job
);

	import wnws_pkg::*;

	localparam int unsigned LEN_MAX = (1 << LEN_W) - 1;
	localparam int unsigned LEN_CAP = (MAX_WAYPOINTS < LEN_MAX) ? MAX_WAYPOINTS : LEN_MAX;

	logic [LEN_W-1:0]  route_length_q;
	logic              route_valid_q;
	logic [LEN_W-1:0]  len;
	logic [SPAN_W-1:0] last;
	logic [WIN_W-1:0]  win;
	logic              narrow;
	logic [SPAN_W-1:0] win_lo;
	logic [SPAN_W-1:0] win_hi_sum;
	logic [SPAN_W-1:0] win_hi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			route_length_q <= '0;
			route_valid_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROUTE_LENGTH: route_length_q <= cfg_wdata;
				CFG_ROUTE_VALID:  route_valid_q  <= cfg_wdata[0];
			endcase
		end
	end

	always_comb begin
		len        = (route_length_q > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : route_length_q;
		last       = len - 1'b1;
		win        = (hint_window == '0) ? WIN_W'(DEFAULT_WINDOW) : hint_window;
		narrow     = hint_valid && (SPAN_W'(hint_index) < len);
		win_lo     = (hint_index >= win) ? SPAN_W'(hint_index - win) : '0;
		win_hi_sum = SPAN_W'(hint_index) + SPAN_W'(win);
		win_hi     = (win_hi_sum > last) ? last : win_hi_sum;

		job.op        = cmd_t'(command);
		job.miss      = !route_valid_q || (len == '0);
		job.slot      = entry_index;
		job.pos.x     = pos_x;
		job.pos.y     = pos_y;
		job.pos.z     = pos_z;
		job.lo        = narrow ? win_lo : '0;
		job.hi        = narrow ? win_hi : last;
		job.clamp_en  = hint_valid;
		job.floor_idx = (hint_index >= SLOT_W'(BACK_LIMIT)) ?
			hint_index - SLOT_W'(BACK_LIMIT) : '0;
	end

endmodule

/* rtl/wnws_back.sv */
// Back end: waypoint memory, distance pipeline and best-match tracking.
// Depends on wnws_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wnws_back #(
	parameter int unsigned MAX_WAYPOINTS = wnws_pkg::MAX_WAYPOINTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  wnws_pkg::job_t      job,
	input  wnws_pkg::back_ctl_t ctl,
	output logic                job_pop,
	output logic                res_push,
	output wnws_pkg::result_t   res
);

	import wnws_pkg::*;

	localparam int unsigned AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;

	function automatic logic [COORD_W-1:0] abs_diff(input coord_t a, input coord_t b);
		logic [COORD_W:0] d;
		d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		return d[COORD_W] ? COORD_W'(-d) : COORD_W'(d);
	endfunction

	point_t mem [MAX_WAYPOINTS];

	back_state_t state_q;
	back_state_t state_d;

	logic [SPAN_W-1:0] cnt_q;
	logic [SPAN_W-1:0] hi_q;
	point_t            pos_q;
	logic              clamp_q;
	logic [SLOT_W-1:0] floor_q;
	logic [SPAN_W-1:0] best_q;
	logic [DIST_W-1:0] best_d_q;
	logic              best_has_q;

	logic              v_s1, v_s2, v_s3, v_s4;
	logic              last_s1, last_s2, last_s3, last_s4;
	logic [SPAN_W-1:0] idx_s1, idx_s2, idx_s3, idx_s4;
	point_t            rd_s1;
	logic [COORD_W-1:0] mag_x_s2, mag_y_s2, mag_z_s2;
	logic [SQ_W-1:0]   sq_x_s3, sq_y_s3, sq_z_s3;
	logic [DIST_W-1:0] dist_s4;

	logic              start;
	logic              wr_en;
	logic              better;
	logic [SPAN_W-1:0] best_fin;

	assign wr_en  = (state_q == BK_IDLE) && ctl.avail && (job.op == CMD_WRITE) &&
		(32'(job.slot) < MAX_WAYPOINTS);
	assign start  = (state_q == BK_IDLE) && ctl.avail && (job.op == CMD_QUERY) &&
		!job.miss && ctl.room;
	assign better = !best_has_q || (dist_s4 < best_d_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (start) begin
				state_d = BK_SCAN;
			end
			BK_SCAN: if (cnt_q == hi_q) begin
				state_d = BK_WAIT;
			end
			BK_WAIT: if (v_s4 && last_s4) begin
				state_d = BK_DONE;
			end
			BK_DONE: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		job_pop  = 1'b0;
		res_push = 1'b0;
		res      = '0;
		best_fin = (clamp_q && (best_q < SPAN_W'(floor_q))) ? SPAN_W'(floor_q) : best_q;
		unique case (state_q)
			BK_IDLE: begin
				job_pop  = ctl.avail && ((job.op == CMD_WRITE) || ctl.room);
				res_push = ctl.avail && (job.op == CMD_QUERY) && job.miss && ctl.room;
			end
			BK_DONE: begin
				res_push       = 1'b1;
				res.found      = 1'b1;
				res.best_index = SLOT_W'(best_fin);
			end
			BK_SCAN, BK_WAIT: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			best_has_q <= 1'b0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= (state_q == BK_SCAN);
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			if (start) begin
				best_has_q <= 1'b0;
			end else if (v_s4) begin
				best_has_q <= 1'b1;
			end
		end
	end

	// Query context, scan counter and best match
	always_ff @(posedge clk) begin
		if (start) begin
			cnt_q   <= job.lo;
			hi_q    <= job.hi;
			pos_q   <= job.pos;
			clamp_q <= job.clamp_en;
			floor_q <= job.floor_idx;
		end else if (state_q == BK_SCAN) begin
			cnt_q <= cnt_q + 1'b1;
		end
		if (v_s4 && better) begin
			best_q   <= idx_s4;
			best_d_q <= dist_s4;
		end
	end

	// Waypoint memory, one write or one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[AW'(job.slot)] <= job.pos;
		end
		if (state_q == BK_SCAN) begin
			rd_s1 <= mem[AW'(cnt_q)];
		end
	end

	// Distance pipeline
	always_ff @(posedge clk) begin
		last_s1  <= (cnt_q == hi_q);
		idx_s1   <= cnt_q;
		last_s2  <= last_s1;
		idx_s2   <= idx_s1;
		mag_x_s2 <= abs_diff(rd_s1.x, pos_q.x);
		mag_y_s2 <= abs_diff(rd_s1.y, pos_q.y);
		mag_z_s2 <= abs_diff(rd_s1.z, pos_q.z);
		last_s3  <= last_s2;
		idx_s3   <= idx_s2;
		sq_x_s3  <= mag_x_s2 * mag_x_s2;
		sq_y_s3  <= mag_y_s2 * mag_y_s2;
		sq_z_s3  <= mag_z_s2 * mag_z_s2;
		last_s4  <= last_s3;
		idx_s4   <= idx_s3;
		dist_s4  <= DIST_W'(sq_x_s3) + DIST_W'(sq_y_s3) + DIST_W'(sq_z_s3);
	end

	`ASSERT_CLK(a_push_room, res_push |-> ctl.room, "result transfer into a full queue")
	`ASSERT_CLK(a_scan_bound, (state_q == BK_SCAN) |-> (cnt_q <= hi_q), "scan ran past window")
	`ASSERT_CLK(a_done_best, (state_q == BK_DONE) |-> best_has_q, "query done without a match")
	`ASSERT_NEVER(a_pipe_idle, (state_q == BK_IDLE) && (v_s1 || v_s2 || v_s3 || v_s4), "stray pipe data")

endmodule

/* rtl/windowed_nearest_waypoint_search_core.sv */
// Windowed nearest waypoint search: a waypoint store written one slot per command,
// searched for the point of least squared distance to a query position. A write
// leaves the command queue while the search engine is idle. A query that reports not
// found is answered from the idle state without a search; a query that searches N
// waypoints reads them through the single read port of the waypoint memory (one
// waypoint per cycle) into the four-stage distance pipeline. The default window of 24
// covers up to 49 waypoints. Two commands and two results can wait in queues,
// so input and output stall independently. Waypoints read before they are written
// return undefined data; there is no clearing pass after reset.
// Depends on wnws_pkg, wnws_fifo, wnws_front and wnws_back.
`timescale 1ns / 1ps

module windowed_nearest_waypoint_search_core #(
	parameter int unsigned MAX_WAYPOINTS = wnws_pkg::MAX_WAYPOINTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [wnws_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wnws_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            push,
	output logic                            full,
	input  logic                            command,
	input  logic [wnws_pkg::SLOT_W-1:0]     entry_index,
	input  wnws_pkg::coord_t                pos_x,
	input  wnws_pkg::coord_t                pos_y,
	input  wnws_pkg::coord_t                pos_z,
	input  logic                            hint_valid,
	input  logic [wnws_pkg::SLOT_W-1:0]     hint_index,
	input  logic [wnws_pkg::WIN_W-1:0]      hint_window,
	output logic                            empty,
	input  logic                            pop,
	output logic                            found,
	output logic [wnws_pkg::SLOT_W-1:0]     best_index
);

	import wnws_pkg::*;

	localparam int unsigned JOB_W = $bits(job_t);
	localparam int unsigned RES_W = $bits(result_t);

	job_t             job_in;
	job_t             job_head;
	logic [JOB_W-1:0] job_rdata;
	logic             job_empty;
	logic             job_pop;
	back_ctl_t        ctl;
	logic             res_push;
	logic             res_full;
	result_t          res_in;
	result_t          res_head;
	logic [RES_W-1:0] res_rdata;

	wnws_front #(
		.MAX_WAYPOINTS(MAX_WAYPOINTS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.command    (command),
		.entry_index(entry_index),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.hint_valid (hint_valid),
		.hint_index (hint_index),
		.hint_window(hint_window),
		.job        (job_in)
	);

	wnws_fifo #(
		.WIDTH(JOB_W),
		.DEPTH(CMD_Q_DEPTH)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (JOB_W'(job_in)),
		.pop   (job_pop),
		.rdata (job_rdata),
		.full  (full),
		.empty (job_empty)
	);

	assign job_head  = job_t'(job_rdata);
	assign ctl.avail = !job_empty;
	assign ctl.room  = !res_full;

	wnws_back #(
		.MAX_WAYPOINTS(MAX_WAYPOINTS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.job     (job_head),
		.ctl     (ctl),
		.job_pop (job_pop),
		.res_push(res_push),
		.res     (res_in)
	);

	wnws_fifo #(
		.WIDTH(RES_W),
		.DEPTH(RES_Q_DEPTH)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (RES_W'(res_in)),
		.pop   (pop),
		.rdata (res_rdata),
		.full  (res_full),
		.empty (empty)
	);

	assign res_head   = result_t'(res_rdata);
	assign found      = res_head.found;
	assign best_index = res_head.best_index;

endmodule
